[rtl/core/frame_deframer_crc32_check_core_macros.svh]
// Assertion macros for the frame deframer core.
`ifndef FRAME_DEFRAMER_CRC32_CHECK_CORE_MACROS_SVH
`define FRAME_DEFRAMER_CRC32_CHECK_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop on every rising edge, skipped while rst is high.
`define FDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop on every rising edge, reset included.
`define FDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FDC_ASSERT(lbl, clk, rst, prop, msg)
`define FDC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/core/fdc_pkg.sv]
// Shared types and constants of the frame deframer core.
`timescale 1ns / 1ps

package fdc_pkg;

   localparam logic [31:0] MAGIC_WORD    = 32'h444E_4152;
   localparam logic [32:0] HEADER_BYTES  = 33'd16;
   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
   localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

   // Frame verdict codes
   localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
   localparam logic [1:0] STATUS_OK         = 2'd1;
   localparam logic [1:0] STATUS_INVALID    = 2'd2;

   typedef logic [7:0]  req_type;
   typedef logic [31:0] csr_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        frame_done;
      logic [1:0]  status;
      logic [15:0] version_out;
      logic [15:0] msg_kind;
      logic [32:0] frame_length;
   } rsp_type;

endpackage

[rtl/core/fdc_stream_if.sv]
// Valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps

interface fdc_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/fdc_crc_step.sv]
// One-byte update of the reflected CRC-32.
`timescale 1ns / 1ps

module fdc_crc_step
   import fdc_pkg::*;
(
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);

   always_comb begin
      logic [31:0] c;
      c = crc_cur ^ {24'h0, data_byte};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_next = c;
   end

endmodule

[rtl/core/frame_deframer_crc32_check_core.sv]
// Top level of the length-prefixed frame deframer with CRC-32 check.
//
//  channel | dir | handshake       | item
//  --------+-----+-----------------+----------------------------------------
//  req     | in  | valid && ready  | data_byte, one stream byte
//  rsp     | out | valid && ready  | payload byte, verdict, header fields
//  csr     | in  | valid && ready  | max_payload_len (ready is high out of reset)
//
// Throughput is one item per cycle unless rsp stalls: the byte sits in an input
// register, the header parse and the one-byte CRC step are combinational logic
// and the result lands in the output register.
// An accepted byte passes the input register and then the output register.
// A stalled rsp holds the output register; the input register keeps its byte
// and req.ready drops only when both registers are full and rsp stalls.
// Reset is synchronous, holds every ready low and returns the parser to
// header byte 0.
`timescale 1ns / 1ps
`include "frame_deframer_crc32_check_core_macros.svh"

module frame_deframer_crc32_check_core
   import fdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   fdc_stream_if.sink   req,
   fdc_stream_if.source rsp,
   fdc_stream_if.sink   csr
);

   // Parser phase codes
   localparam logic PHASE_HEADER  = 1'b0;
   localparam logic PHASE_PAYLOAD = 1'b1;

   // Input register
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;

   // Parser state
   logic        phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [15:0] version_ff, version_in;
   logic [15:0] type_ff, type_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] exp_crc_ff, exp_crc_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] max_len_ff;

   // Output register
   logic    out_valid_ff;
   rsp_type out_data_ff;

   logic        advance;
   logic        req_fire;
   logic [31:0] crc_step;
   rsp_type     res;

   // Move the held byte forward when the output register is free or drains.
   assign advance  = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !reset && (!s1_valid_ff || advance);
   assign req_fire = req.valid && req.ready;

   assign csr.ready   = !reset;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_data_ff;

   fdc_crc_step u_crc (
      .crc_cur   (crc_ff),
      .data_byte (s1_byte_ff),
      .crc_next  (crc_step)
   );

   // Parse one byte: header field capture or payload pass-through.
   always_comb begin
      logic ok;
      logic done;
      ok         = 1'b0;
      done       = 1'b0;
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      version_in = version_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      exp_crc_in = exp_crc_ff;
      crc_in     = crc_ff;
      left_in    = left_ff;
      res        = '0;

      if (phase_ff == PHASE_PAYLOAD) begin
         res.payload_valid = 1'b1;
         res.payload_byte  = s1_byte_ff;
         crc_in            = crc_step;
         left_in           = left_ff - 32'd1;
         if (left_ff == 32'd1) begin
            // Last payload byte: compare the finished CRC.
            done = 1'b1;
            ok   = ((crc_step ^ CRC_INIT) == exp_crc_ff);
         end
      end else begin
         priority if (hdr_idx_ff < 4'd4) begin
            // Magic gathers in the length register.
            if (hdr_idx_ff == 4'd0) length_in = '0;
            length_in[{hdr_idx_ff[1:0], 3'b000} +: 8] = s1_byte_ff;
            if (hdr_idx_ff == 4'd3 && length_in != MAGIC_WORD) done = 1'b1;
         end else if (hdr_idx_ff < 4'd6) begin
            if (hdr_idx_ff == 4'd4) version_in = '0;
            version_in[{hdr_idx_ff[0], 3'b000} +: 8] = s1_byte_ff;
         end else if (hdr_idx_ff < 4'd8) begin
            if (hdr_idx_ff == 4'd6) type_in = '0;
            type_in[{hdr_idx_ff[0], 3'b000} +: 8] = s1_byte_ff;
         end else if (hdr_idx_ff < 4'd12) begin
            if (hdr_idx_ff == 4'd8) length_in = '0;
            length_in[{hdr_idx_ff[1:0], 3'b000} +: 8] = s1_byte_ff;
         end else begin
            if (hdr_idx_ff == 4'd12) exp_crc_in = '0;
            exp_crc_in[{hdr_idx_ff[1:0], 3'b000} +: 8] = s1_byte_ff;
            if (hdr_idx_ff == 4'd15) begin
               if (length_ff > max_len_ff) begin
                  done = 1'b1;
               end else if (length_ff == 32'd0) begin
                  // Empty payload: CRC of no bytes is zero.
                  done = 1'b1;
                  ok   = (exp_crc_in == 32'd0);
               end
            end
         end

         if (!done) begin
            if (hdr_idx_ff == 4'd15) begin
               phase_in   = PHASE_PAYLOAD;
               left_in    = length_ff;
               crc_in     = CRC_INIT;
               hdr_idx_in = '0;
            end else begin
               hdr_idx_in = hdr_idx_ff + 4'd1;
            end
         end
      end

      if (done) begin
         res.frame_done = 1'b1;
         res.status     = ok ? STATUS_OK : STATUS_INVALID;
         // Restart on the next byte.
         phase_in   = PHASE_HEADER;
         hdr_idx_in = '0;
         crc_in     = CRC_INIT;
         left_in    = '0;
      end

      if (ok) begin
         res.version_out  = version_in;
         res.msg_kind     = type_in;
         res.frame_length = {1'b0, length_in} + HEADER_BYTES;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PHASE_HEADER;
         hdr_idx_ff   <= '0;
         crc_ff       <= CRC_INIT;
         left_ff      <= '0;
         max_len_ff   <= MAX_LEN_RESET;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            hdr_idx_ff   <= hdr_idx_in;
            crc_ff       <= crc_in;
            left_ff      <= left_in;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end

         if (csr.valid) begin
            max_len_ff <= csr.payload;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req.payload;
      end
      if (advance) begin
         out_data_ff <= res;
         version_ff  <= version_in;
         type_ff     <= type_in;
         length_ff   <= length_in;
         exp_crc_ff  <= exp_crc_in;
      end
   end

   // Terms the checks below look at
   logic out_done_ok;
   logic in_payload;
   logic out_stalled;

   assign out_done_ok = (out_data_ff.frame_done == (out_data_ff.status != STATUS_INCOMPLETE));
   assign in_payload  = (phase_ff == PHASE_PAYLOAD);
   assign out_stalled = s1_valid_ff && out_valid_ff && !rsp.ready;

   // A verdict is given exactly when the frame ends.
   `FDC_ASSERT(a_done_status, clock, reset, rsp.valid |-> out_done_ok, "verdict mismatch")

   // In the payload phase at least one byte is still owed.
   `FDC_ASSERT(a_left_nonzero, clock, reset, in_payload |-> left_ff != '0, "no bytes left")

   // The header counter rests at zero while payload flows.
   `FDC_ASSERT(a_idx_rest, clock, reset, in_payload |-> hdr_idx_ff == '0, "index moved")

   // Both registers full and the output stalled: no new item may enter.
   `FDC_ASSERT(a_full_stall, clock, reset, out_stalled |-> !req.ready, "item taken while full")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the frame deframer core with CRC-32 payload check.
`timescale 1ns / 1ps

module testbench;
   import fdc_pkg::*;

   // Parser phase codes of the local predictor
   localparam logic [1:0] PHASE_HEADER  = 2'd0;
   localparam logic [1:0] PHASE_PAYLOAD = 2'd1;

   // Pipeline depth from req acceptance to rsp valid, plus margin
   localparam int SETTLE_CYCLES = 4;

   logic clock = 1'b0;
   logic reset;

   fdc_stream_if #(.payload_type(req_type)) req_if ();
   fdc_stream_if #(.payload_type(rsp_type)) rsp_if ();
   fdc_stream_if #(.payload_type(csr_type)) csr_if ();

   frame_deframer_crc32_check_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always #4 clock = ~clock;

   // Predictor state, starting from the reset values of the block
   logic [1:0]  prs_phase     = PHASE_HEADER;
   logic [3:0]  prs_index     = '0;
   logic [15:0] prs_version   = '0;
   logic [15:0] prs_type      = '0;
   logic [31:0] prs_length    = '0;
   logic [31:0] prs_crc_field = '0;
   logic [31:0] prs_crc       = CRC_INIT;
   logic [31:0] prs_left      = '0;
   logic [31:0] max_len       = MAX_LEN_RESET;

   rsp_type predicted_outputs[$];
   req_type payload_bytes[$];

   int mismatch_count = 0;
   int bytes_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_each_byte = 1'b0;

   // One byte of the reflected CRC-32, LSB first
   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // Advance the predictor by one stream byte and return the expected rsp item
   function automatic rsp_type deframe_byte(input req_type b);
      rsp_type    r;
      logic [4:0] sh;
      logic       ok;
      r  = '0;
      ok = 1'b0;
      sh = {prs_index[1:0], 3'b000};
      r.status = STATUS_INCOMPLETE;
      if (prs_phase == PHASE_PAYLOAD) begin
         r.payload_valid = 1'b1;
         r.payload_byte  = b;
         prs_crc  = crc_step(prs_crc, b);
         prs_left = prs_left - 32'd1;
         if (prs_left == 32'd0) begin
            r.frame_done = 1'b1;
            ok       = (~prs_crc == prs_crc_field);
            r.status = ok ? STATUS_OK : STATUS_INVALID;
         end
      end else begin
         // Any phase code other than payload parses header bytes
         if (prs_index < 4'd4) begin
            if (prs_index == 4'd0)
               prs_length = '0;
            prs_length |= {24'd0, b} << sh;
            if (prs_index == 4'd3 && prs_length != MAGIC_WORD) begin
               r.frame_done = 1'b1;
               r.status     = STATUS_INVALID;
            end
         end else if (prs_index < 4'd6) begin
            if (prs_index == 4'd4)
               prs_version = '0;
            prs_version |= {8'd0, b} << {prs_index[0], 3'b000};
         end else if (prs_index < 4'd8) begin
            if (prs_index == 4'd6)
               prs_type = '0;
            prs_type |= {8'd0, b} << {prs_index[0], 3'b000};
         end else if (prs_index < 4'd12) begin
            if (prs_index == 4'd8)
               prs_length = '0;
            prs_length |= {24'd0, b} << sh;
         end else begin
            if (prs_index == 4'd12)
               prs_crc_field = '0;
            prs_crc_field |= {24'd0, b} << sh;
            if (prs_index == 4'd15) begin
               if (prs_length > max_len) begin
                  r.frame_done = 1'b1;
                  r.status     = STATUS_INVALID;
               end else if (prs_length == 32'd0) begin
                  // Empty payload: CRC of no bytes is zero
                  r.frame_done = 1'b1;
                  ok       = (prs_crc_field == 32'd0);
                  r.status = ok ? STATUS_OK : STATUS_INVALID;
               end
            end
         end
         if (!r.frame_done) begin
            if (prs_index == 4'd15) begin
               prs_phase = PHASE_PAYLOAD;
               prs_left  = prs_length;
               prs_crc   = CRC_INIT;
               prs_index = '0;
            end else begin
               prs_index = prs_index + 4'd1;
            end
         end
      end
      if (ok) begin
         r.version_out  = prs_version;
         r.msg_kind     = prs_type;
         r.frame_length = {1'b0, prs_length} + HEADER_BYTES;
      end
      if (r.frame_done) begin
         prs_phase = PHASE_HEADER;
         prs_index = '0;
         prs_crc   = CRC_INIT;
         prs_left  = '0;
      end
      return r;
   endfunction

   task automatic compare_result(input rsp_type want, input rsp_type got);
      if (got.payload_valid !== want.payload_valid) begin
         $error("payload_valid: expected %0d, actual %0d", want.payload_valid,
                got.payload_valid);
         mismatch_count++;
      end
      if (got.payload_byte !== want.payload_byte) begin
         $error("payload_byte: expected 0x%02h, actual 0x%02h", want.payload_byte,
                got.payload_byte);
         mismatch_count++;
      end
      if (got.frame_done !== want.frame_done) begin
         $error("frame_done: expected %0d, actual %0d", want.frame_done, got.frame_done);
         mismatch_count++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         mismatch_count++;
      end
      if (got.version_out !== want.version_out) begin
         $error("version_out: expected 0x%04h, actual 0x%04h", want.version_out,
                got.version_out);
         mismatch_count++;
      end
      if (got.msg_kind !== want.msg_kind) begin
         $error("msg_kind: expected 0x%04h, actual 0x%04h", want.msg_kind,
                got.msg_kind);
         mismatch_count++;
      end
      if (got.frame_length !== want.frame_length) begin
         $error("frame_length: expected %0d, actual %0d", want.frame_length,
                got.frame_length);
         mismatch_count++;
      end
   endtask

   // Sample all three channels at the rising edge. Pop before queueing so a
   // result is only ever matched against items accepted at earlier edges.
   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("rsp item arrived with no prediction pending");
               mismatch_count++;
            end else begin
               want = predicted_outputs.pop_front();
               compare_result(want, rsp_if.payload);
            end
         end
         if (csr_if.valid && csr_if.ready)
            max_len = csr_if.payload;
         if (req_if.valid && req_if.ready)
            predicted_outputs = {predicted_outputs, deframe_byte(req_if.payload)};
      end
   end

   // Stall the result channel at the configured rate
   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);

   // Drop req valid, hold until every prediction is matched, then let the
   // pipeline settle. Called and returns at a falling edge.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (predicted_outputs.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Offer one byte and hold it until accepted. Called and returns at a falling edge.
   task automatic send_byte(input req_type b);
      if (hold_each_byte || $urandom_range(199) == 0)
         wait_drained();
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= b;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [31:0] value, input int count);
      for (int i = 0; i < count; i++)
         send_byte(value[8*i +: 8]);
   endtask

   task automatic write_max_len(input csr_type value);
      wait_drained();
      csr_if.valid   <= 1'b1;
      csr_if.payload <= value;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic void fill_payload(input int count);
      payload_bytes.delete();
      for (int i = 0; i < count; i++)
         payload_bytes = {payload_bytes, 8'($urandom)};
   endfunction

   function automatic logic [31:0] payload_crc();
      logic [31:0] c;
      c = CRC_INIT;
      foreach (payload_bytes[i])
         c = crc_step(c, payload_bytes[i]);
      return ~c;
   endfunction

   // Send a header and then payload_bytes; crc_flip corrupts the CRC field
   task automatic send_frame(input logic [31:0] magic, input logic [15:0] version,
                             input logic [15:0] msg_type, input logic [31:0] length,
                             input logic [31:0] crc_flip);
      logic [31:0] crc;
      crc = payload_crc() ^ crc_flip;
      send_word(magic, 4);
      send_word({16'd0, version}, 2);
      send_word({16'd0, msg_type}, 2);
      send_word(length, 4);
      send_word(crc, 4);
      foreach (payload_bytes[i])
         send_byte(payload_bytes[i]);
   endtask

   // Mostly well-formed frames with random content, the rest broken or noise
   task automatic send_random_frame();
      int          pick;
      int          count;
      logic [31:0] length;
      pick  = $urandom_range(99);
      count = ($urandom_range(29) == 0) ? $urandom_range(300) : $urandom_range(24);
      fill_payload(count);
      length = count;
      if (pick < 60) begin
         // good frame, one in ten with a flipped CRC bit
         send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), length,
                    ($urandom_range(9) == 0) ? (32'd1 << $urandom_range(31)) : 32'd0);
      end else if (pick < 68) begin
         // bad magic, remaining bytes get parsed as a fresh header
         send_frame(MAGIC_WORD ^ (32'd1 << $urandom_range(31)), 16'($urandom),
                    16'($urandom), length, 32'd0);
      end else if (pick < 76) begin
         // length above the limit, if the limit allows one; payload bytes then turn into header noise
         if (max_len != 32'hFFFF_FFFF)
            length = (max_len > 32'hFFFF_FF00) ? 32'hFFFF_FFFF
                                               : max_len + 32'd1 + $urandom_range(200);
         send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), length, 32'd0);
      end else if (pick < 86) begin
         // raw noise between frames
         repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
      end else if (pick < 92) begin
         // truncated frame: following bytes are swallowed as payload
         length = count + 1 + $urandom_range(8);
         send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), length, 32'd0);
      end else begin
         // empty payload, CRC field zero or random
         payload_bytes.delete();
         send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), 32'd0,
                    $urandom_range(1) ? 32'd0 : $urandom);
      end
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                   input csr_type limit, input int count);
      int target;
      write_max_len(limit);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      target = bytes_sent + count;
      while (bytes_sent < target)
         send_random_frame();
   endtask

   // Field extremes and every verdict under the reset limit
   task automatic test_directed_frames();
      payload_bytes.delete();
      send_frame(MAGIC_WORD, 16'hFFFF, 16'h0000, 32'd0, 32'd0);       // empty, ok
      send_frame(MAGIC_WORD, 16'h1234, 16'h5678, 32'd0, 32'd1);       // empty, bad CRC
      send_frame(MAGIC_WORD ^ 32'h8000_0000, 16'd0, 16'd0, 32'd0, 32'd0); // bad magic
      payload_bytes = '{8'hFF};
      send_frame(MAGIC_WORD, 16'h0000, 16'hFFFF, 32'd1, 32'd0);       // one byte, ok
      payload_bytes = '{8'h00, 8'h00};
      send_frame(MAGIC_WORD, 16'hA5A5, 16'h5A5A, 32'd2, 32'd0);
      payload_bytes = '{8'h00, 8'hFF, 8'h80};
      send_frame(MAGIC_WORD, 16'h0001, 16'h0002, 32'd3, 32'd1);       // CRC mismatch
      payload_bytes.delete();
      send_frame(MAGIC_WORD, 16'd7, 16'd7, MAX_LEN_RESET + 32'd1, 32'd0); // too long
      send_frame(MAGIC_WORD, 16'd7, 16'd7, 32'hFFFF_FFFF, 32'd0);
   endtask

   // Exact boundary of the limit, and both extremes of the register
   task automatic test_max_len_limits();
      write_max_len(32'd5);
      fill_payload(5);
      send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), 32'd5, 32'd0);
      fill_payload(6);
      send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), 32'd6, 32'd0);
      write_max_len(32'd0);
      payload_bytes.delete();
      send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), 32'd0, 32'd0);
      fill_payload(1);
      send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), 32'd1, 32'd0);
      write_max_len(32'hFFFF_FFFF);
      fill_payload(4);
      send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), 32'd4, 32'd0);
   endtask

   // Drain the block before every byte, in header and payload alike
   task automatic test_hold_until_drained();
      hold_each_byte = 1'b1;
      fill_payload(3);
      send_frame(MAGIC_WORD, 16'($urandom), 16'($urandom), 32'd3, 32'd0);
      send_word($urandom, 4);
      hold_each_byte = 1'b0;
   endtask

   task automatic test_random_traffic();
      run_random_phase(0, 0, 32'hFFFF_FFFF, 450);
      run_random_phase(88, 0, $urandom_range(40, 8), 350);
      run_random_phase(0, 88, MAX_LEN_RESET, 350);
      run_random_phase(26, 26, $urandom, 400);
   endtask

   initial begin : sequencer
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_frames();
      test_max_len_limits();
      test_hold_until_drained();
      test_random_traffic();

      recv_stall_pct = 0;
      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && predicted_outputs.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // Abort a hung run; the slowest correct run is far shorter
   initial begin : watchdog
      #6_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
